@@ src/ils_pkg.sv @@
// indexed list store: shared types and fixed field widths
// used by ils_seq and indexed_list_store_top; no dependencies
package ils_pkg;

  localparam int ACT_W     = 3;
  localparam int POS_W     = 10;
  localparam int VAL_W     = 32;
  localparam int TOTAL_W   = 11;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;
  localparam int S_PAD_W   = S_TDATA_W - POS_W - VAL_W;
  localparam int M_PAD_W   = M_TDATA_W - VAL_W - TOTAL_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND    = 3'd0,
    ACT_READ      = 3'd1,
    ACT_OVERWRITE = 3'd2,
    ACT_INSERT    = 3'd3,
    ACT_REMOVE    = 3'd4,
    ACT_CLEAR     = 3'd5
  } ils_action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_INS_SHIFT,
    S_INS_LAST,
    S_REM_FIRST,
    S_REM_SHIFT,
    S_RESULT
  } ils_state_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } ils_res_t;

endpackage

@@ src/indexed_list_store_top.sv @@
// append, overwrite, clear and failed transactions go from S_IDLE straight to S_RESULT;
// read passes through S_READ; insert moves entries up from the end down to the position
// and then writes the new value, remove moves entries down (one entry moved per cycle)
// a new transaction is accepted only after the last result is taken, which waits on m_tready
// synchronous reset clears the count and control state; the store is not cleared
// depends on ils_pkg, ils_mem, ils_seq
module indexed_list_store_top #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ils_pkg::S_TDATA_W-1:0] s_tdata,  // position, value, zero pad
  input  logic [ils_pkg::ACT_W-1:0]     s_tuser,  // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ils_pkg::M_TDATA_W-1:0] m_tdata,  // read_value, element_total, zero pad
  output logic                          m_tuser   // ok
);

  import ils_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  ils_res_t              res;
  logic                  res_take;
  logic [DATA_WIDTH-1:0] res_value;
  logic [CW-1:0]         res_total;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  logic                  out_valid, out_valid_next;
  logic [M_TDATA_W-1:0]  out_data;
  logic                  out_ok;

  ils_seq #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .action   (s_tuser),
    .position (s_tdata[POS_W-1:0]),
    .value    (s_tdata[POS_W+VAL_W-1:POS_W]),
    .res      (res),
    .res_take (res_take),
    .res_value(res_value),
    .res_total(res_total),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  ils_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(DATA_WIDTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign res_take = res.valid && (!out_valid || m_tready);

  always_comb begin
    if (res_take) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= {{M_PAD_W{1'b0}}, TOTAL_W'(res_total), VAL_W'(res_value)};
      out_ok   <= res.ok;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_ok;

endmodule

@@ src/ils_mem.sv @@
// indexed list store: entry memory, one write and one registered read port
// depends on nothing
module ils_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/ils_seq.sv @@
// indexed list store: request sequencer, element count and shift walk
// depends on ils_pkg; drives the ils_mem ports
module ils_seq #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 10,
  parameter int CW         = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ils_pkg::ACT_W-1:0] action,
  input  logic [ils_pkg::POS_W-1:0] position,
  input  logic [ils_pkg::VAL_W-1:0] value,
  output ils_pkg::ils_res_t         res,
  input  logic                      res_take,
  output logic [DATA_WIDTH-1:0]     res_value,
  output logic [CW-1:0]             res_total,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [DATA_WIDTH-1:0]     mem_wdata,
  output logic [AW-1:0]             mem_raddr,
  input  logic [DATA_WIDTH-1:0]     mem_rdata
);

  import ils_pkg::*;

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  ils_state_t            state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         k, k_next;
  logic [CW-1:0]         pos_r, pos_r_next;
  logic [DATA_WIDTH-1:0] word_r, word_r_next;
  logic [DATA_WIDTH-1:0] got, got_next;
  logic                  ok_r, ok_next;

  ils_action_t           act;
  logic [CMPW-1:0]       pos_ext, cnt_ext;
  logic [DATA_WIDTH-1:0] word_in;
  logic                  pos_lt, pos_le, full, accept;
  logic [CW:0]           k_inc1, k_inc2;
  logic                  ins_more, rem_any, rem_more;

  assign act      = ils_action_t'(action);
  assign pos_ext  = CMPW'(position);
  assign cnt_ext  = CMPW'(count);
  assign word_in  = DATA_WIDTH'(value);
  assign pos_lt   = pos_ext < cnt_ext;
  assign pos_le   = pos_ext <= cnt_ext;
  assign full     = count == CW'(CAPACITY);
  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign k_inc1   = {1'b0, k} + (CW+1)'(1);
  assign k_inc2   = {1'b0, k} + (CW+1)'(2);
  assign ins_more = (k - CW'(1)) > pos_r;
  assign rem_any  = k_inc1 < {1'b0, count};
  assign rem_more = k_inc2 < {1'b0, count};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (act)
            ACT_READ:    state_next = pos_lt ? S_READ : S_RESULT;
            ACT_INSERT: begin
              if (pos_le && !full) begin
                state_next = pos_lt ? S_INS_SHIFT : S_INS_LAST;
              end else begin
                state_next = S_RESULT;
              end
            end
            ACT_REMOVE:  state_next = pos_lt ? S_REM_FIRST : S_RESULT;
            default:     state_next = S_RESULT;
          endcase
        end
      end
      S_READ:      state_next = S_RESULT;
      S_INS_SHIFT: state_next = ins_more ? S_INS_SHIFT : S_INS_LAST;
      S_INS_LAST:  state_next = S_RESULT;
      S_REM_FIRST: state_next = rem_any ? S_REM_SHIFT : S_RESULT;
      S_REM_SHIFT: state_next = rem_more ? S_REM_SHIFT : S_RESULT;
      S_RESULT:    state_next = res_take ? S_IDLE : S_RESULT;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next  = count;
    k_next      = k;
    pos_r_next  = pos_r;
    word_r_next = word_r;
    got_next    = got;
    ok_next     = ok_r;
    mem_we      = 1'b0;
    mem_waddr   = k[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = k[AW-1:0];
    res.valid   = 1'b0;
    res.ok      = ok_r;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          pos_r_next  = CW'(pos_ext);
          word_r_next = word_in;
          got_next    = '0;
          ok_next     = 1'b0;
          unique case (act)
            ACT_APPEND: begin
              if (!full) begin
                mem_we     = 1'b1;
                mem_waddr  = count[AW-1:0];
                mem_wdata  = word_in;
                count_next = count + CW'(1);
                ok_next    = 1'b1;
              end
            end
            ACT_READ: begin
              mem_raddr = AW'(pos_ext);
              ok_next   = pos_lt;
            end
            ACT_OVERWRITE: begin
              if (pos_lt) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(pos_ext);
                mem_wdata = word_in;
                ok_next   = 1'b1;
              end
            end
            ACT_INSERT: begin
              mem_raddr = AW'(count - CW'(1));
              k_next    = count;
              ok_next   = pos_le && !full;
            end
            ACT_REMOVE: begin
              mem_raddr = AW'(pos_ext);
              k_next    = CW'(pos_ext);
              ok_next   = pos_lt;
            end
            ACT_CLEAR: begin
              count_next = '0;
              ok_next    = 1'b1;
            end
            default: ok_next = 1'b0;
          endcase
        end
      end
      S_READ: begin
        got_next = mem_rdata;
      end
      S_INS_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = k[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = AW'(k - CW'(2));
        k_next    = k - CW'(1);
      end
      S_INS_LAST: begin
        mem_we     = 1'b1;
        mem_waddr  = pos_r[AW-1:0];
        mem_wdata  = word_r;
        count_next = count + CW'(1);
      end
      S_REM_FIRST: begin
        got_next  = mem_rdata;
        mem_raddr = AW'(k_inc1);
        if (!rem_any) begin
          count_next = count - CW'(1);
        end
      end
      S_REM_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = k[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = AW'(k_inc2);
        k_next    = k_inc1[CW-1:0];
        if (!rem_more) begin
          count_next = count - CW'(1);
        end
      end
      S_RESULT: begin
        res.valid = 1'b1;
      end
      default: res.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    k      <= k_next;
    pos_r  <= pos_r_next;
    word_r <= word_r_next;
    got    <= got_next;
    ok_r   <= ok_next;
  end

  assign res_value = got;
  assign res_total = count;

`ifndef SYNTHESIS
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    accept && act == ACT_APPEND && !full |=> count == $past(count) + CW'(1))
    else $error("append did not grow the count");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && act == ACT_CLEAR |=> count == '0)
    else $error("clear left entries");

  a_ins_walk_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_SHIFT |-> (k > pos_r) && (k <= count))
    else $error("insert walk out of range");

  a_fail_reads_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ok |-> res_value == '0)
    else $error("failed transaction returned data");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res_total <= CW'(CAPACITY))
    else $error("count above capacity");
`endif

endmodule
